// ===== sv/ppp_pkg.sv =====
package ppp_pkg;

   // Fraction bits of the result fields.
   localparam int OUT_FRAC_BITS = 16;

   // Register indexes.
   localparam logic [2:0] REG_P_ROW0_A   = 3'd0;
   localparam logic [2:0] REG_P_ROW0_B   = 3'd1;
   localparam logic [2:0] REG_P_ROW1_A   = 3'd2;
   localparam logic [2:0] REG_P_ROW1_B   = 3'd3;
   localparam logic [2:0] REG_P_ROW2_A   = 3'd4;
   localparam logic [2:0] REG_P_ROW2_B   = 3'd5;
   localparam logic [2:0] REG_IMAGE_ROWS = 3'd6;

   localparam logic [15:0] IMAGE_ROWS_RESET = 16'd480;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DIV  = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   // Control that travels with each item through the divider stages.
   typedef struct packed {
      logic valid;
      logic zero;
      logic neg_u;
      logic neg_v;
      logic ovf_u;
      logic ovf_v;
   } ctl_type;

endpackage

// ===== sv/ppp_req_if.sv =====
interface ppp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic signed [31:0] point_h;

   modport source(output valid, point_x, point_y, point_z, point_h, input ready);
   modport sink(input valid, point_x, point_y, point_z, point_h, output ready);
endinterface

// ===== sv/ppp_rsp_if.sv =====
interface ppp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] image_col;
   logic signed [31:0] image_row;
   logic [1:0]         status;

   modport source(output valid, image_col, image_row, status, input ready);
   modport sink(input valid, image_col, image_row, status, output ready);
endinterface

// ===== sv/ppp_div_stage.sv =====
module ppp_div_stage #(
   parameter int W   = 100,
   parameter int QB  = 34,
   parameter int BIT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  ppp_pkg::ctl_type ctl_in,
   input  logic [W-1:0]     den_in,
   input  logic [W-1:0]     rem_u_in,
   input  logic [W-1:0]     rem_v_in,
   input  logic [QB-1:0]    quo_u_in,
   input  logic [QB-1:0]    quo_v_in,
   output ppp_pkg::ctl_type ctl_out,
   output logic [W-1:0]     den_out,
   output logic [W-1:0]     rem_u_out,
   output logic [W-1:0]     rem_v_out,
   output logic [QB-1:0]    quo_u_out,
   output logic [QB-1:0]    quo_v_out
);

   logic [W-1:0]     den_shift;
   logic             ge_u, ge_v;
   ppp_pkg::ctl_type ctl_ff;
   logic [W-1:0]     den_ff, rem_u_ff, rem_v_ff, rem_u_in_nx, rem_v_in_nx;
   logic [QB-1:0]    quo_u_ff, quo_v_ff, quo_u_in_nx, quo_v_in_nx;

   // One restoring step per lane: try to take the shifted divisor off the remainder.
   always_comb begin
      den_shift   = den_in << BIT;
      ge_u        = rem_u_in >= den_shift;
      ge_v        = rem_v_in >= den_shift;
      rem_u_in_nx = ge_u ? rem_u_in - den_shift : rem_u_in;
      rem_v_in_nx = ge_v ? rem_v_in - den_shift : rem_v_in;
      quo_u_in_nx = quo_u_in;
      quo_v_in_nx = quo_v_in;
      quo_u_in_nx[BIT] = ge_u;
      quo_v_in_nx[BIT] = ge_v;
   end

   // Control carries a valid bit and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   // Payload of the stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff   <= den_in;
         rem_u_ff <= rem_u_in_nx;
         rem_v_ff <= rem_v_in_nx;
         quo_u_ff <= quo_u_in_nx;
         quo_v_ff <= quo_v_in_nx;
      end
   end

   assign ctl_out   = ctl_ff;
   assign den_out   = den_ff;
   assign rem_u_out = rem_u_ff;
   assign rem_v_out = rem_v_ff;
   assign quo_u_out = quo_u_ff;
   assign quo_v_out = quo_v_ff;

endmodule

// ===== sv/pinhole_point_projection_core.sv =====
// Channel   Direction  Handshake     Payload
// req       in         valid/ready   point_x, point_y, point_z, point_h
// rsp       out        valid/ready   image_col, image_row, status
// csr       in (APB)   psel/penable  64-bit coefficient pairs, image_rows
//
// One transaction enters per cycle while rsp is not stalled; its result passes through the
// product, row-sum and magnitude stages, the one-bit-per-stage divider pipeline with
// QB = max(OUT_FRAC_BITS + 18, 33) quotient bits, and the output register. Reset clears all
// valid bits and loads the register reset values. A stall on rsp holds the whole pipeline in place.
module pinhole_point_projection_core #(
   parameter int OUT_FRAC_BITS = ppp_pkg::OUT_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   ppp_req_if.sink     req,
   ppp_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   localparam int F  = OUT_FRAC_BITS;
   localparam int QB = (F + 18 > 33) ? F + 18 : 33;
   localparam int W  = 66 + QB;
   localparam int RW = QB + 3;

   logic [63:0] p_regs_ff [6];
   logic [15:0] image_rows_ff;
   logic [2:0]  reg_index;
   logic        advance;

   // Configuration registers.
   assign reg_index = paddr[5:3];
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) p_regs_ff[i] <= '0;
         image_rows_ff <= ppp_pkg::IMAGE_ROWS_RESET;
      end else if (psel && penable && pwrite) begin
         if (reg_index == ppp_pkg::REG_IMAGE_ROWS) begin
            image_rows_ff <= pwdata[15:0];
         end else if (reg_index != 3'd7) begin
            p_regs_ff[reg_index] <= pwdata;
         end
      end
   end

   always_comb begin
      case (reg_index)
         ppp_pkg::REG_P_ROW0_A, ppp_pkg::REG_P_ROW0_B, ppp_pkg::REG_P_ROW1_A,
         ppp_pkg::REG_P_ROW1_B, ppp_pkg::REG_P_ROW2_A,
         ppp_pkg::REG_P_ROW2_B: prdata = p_regs_ff[reg_index];
         ppp_pkg::REG_IMAGE_ROWS: prdata = {48'd0, image_rows_ff};
         default: prdata = '0;
      endcase
   end

   // The whole pipeline moves when the output register is free or taken.
   logic out_valid_ff;
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance && !reset;

   // Stage 1: twelve products.
   logic               v1_ff;
   logic signed [63:0] prod_ff [3][4];
   logic signed [31:0] pt [4];

   assign pt[0] = req.point_x;
   assign pt[1] = req.point_y;
   assign pt[2] = req.point_z;
   assign pt[3] = req.point_h;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
               prod_ff[r][c] <= $signed(p_regs_ff[r*2 + c/2][(c%2)*32 +: 32]) * pt[c];
            end
         end
      end
   end

   // Stage 2: row sums u, v, w.
   logic               v2_ff;
   logic signed [65:0] sum_ff [3];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            sum_ff[r] <= 66'(prod_ff[r][0]) + 66'(prod_ff[r][1])
                       + 66'(prod_ff[r][2]) + 66'(prod_ff[r][3]);
         end
      end
   end

   // Stage 3: magnitudes and signs.
   logic        v3_ff, neg_u3_ff, neg_v3_ff, neg_w3_ff;
   logic [64:0] mag_u3_ff, mag_v3_ff, mag_w3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_u3_ff <= sum_ff[0][65];
         neg_v3_ff <= sum_ff[1][65];
         neg_w3_ff <= sum_ff[2][65];
         mag_u3_ff <= sum_ff[0][65] ? 65'(-sum_ff[0]) : sum_ff[0][64:0];
         mag_v3_ff <= sum_ff[1][65] ? 65'(-sum_ff[1]) : sum_ff[1][64:0];
         mag_w3_ff <= sum_ff[2][65] ? 65'(-sum_ff[2]) : sum_ff[2][64:0];
      end
   end

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Stage 4 input: quotient range check and divider setup. A quotient of
   // 2^QB or more saturates either output, so QB quotient bits suffice.
   ppp_pkg::ctl_type ctl_s [QB+1];
   logic [W-1:0]     den_s [QB+1];
   logic [W-1:0]     rem_u_s [QB+1];
   logic [W-1:0]     rem_v_s [QB+1];
   logic [QB-1:0]    quo_u_s [QB+1];
   logic [QB-1:0]    quo_v_s [QB+1];
   logic [W-1:0]     den_limit;

   assign den_limit       = W'(mag_w3_ff) << (QB - F);
   assign ctl_s[0].valid  = v3_ff;
   assign ctl_s[0].zero   = (mag_w3_ff == '0);
   assign ctl_s[0].neg_u  = neg_u3_ff ^ neg_w3_ff;
   assign ctl_s[0].neg_v  = neg_v3_ff ^ neg_w3_ff;
   assign ctl_s[0].ovf_u  = W'(mag_u3_ff) >= den_limit;
   assign ctl_s[0].ovf_v  = W'(mag_v3_ff) >= den_limit;
   assign den_s[0]        = W'(mag_w3_ff);
   assign rem_u_s[0]      = W'(mag_u3_ff) << F;
   assign rem_v_s[0]      = W'(mag_v3_ff) << F;
   assign quo_u_s[0]      = '0;
   assign quo_v_s[0]      = '0;

   // Divider: one quotient bit per stage, most significant first.
   for (genvar k = 0; k < QB; k++) begin : g_div
      ppp_div_stage #(.W(W), .QB(QB), .BIT(QB - 1 - k)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .ctl_in    (ctl_s[k]),
         .den_in    (den_s[k]),
         .rem_u_in  (rem_u_s[k]),
         .rem_v_in  (rem_v_s[k]),
         .quo_u_in  (quo_u_s[k]),
         .quo_v_in  (quo_v_s[k]),
         .ctl_out   (ctl_s[k+1]),
         .den_out   (den_s[k+1]),
         .rem_u_out (rem_u_s[k+1]),
         .rem_v_out (rem_v_s[k+1]),
         .quo_u_out (quo_u_s[k+1]),
         .quo_v_out (quo_v_s[k+1])
      );
   end

   // Final stage: signs, row flip, clamping and status.
   ppp_pkg::ctl_type   ctl_f;
   logic signed [RW-1:0] qu, qv, row_off, row_full;
   logic signed [31:0]   col_nx, row_nx;
   logic                 sat_col, sat_row;
   logic [1:0]           status_nx;

   localparam logic signed [RW-1:0] S32_MAX = RW'(64'sd2147483647);
   localparam logic signed [RW-1:0] S32_MIN = -RW'(64'sd2147483648);

   always_comb begin
      ctl_f    = ctl_s[QB];
      qu       = ctl_f.neg_u ? -$signed(RW'(quo_u_s[QB])) : $signed(RW'(quo_u_s[QB]));
      qv       = ctl_f.neg_v ? -$signed(RW'(quo_v_s[QB])) : $signed(RW'(quo_v_s[QB]));
      row_off  = ($signed(RW'(image_rows_ff)) - RW'(1)) <<< F;
      row_full = row_off - qu;
      sat_col  = 1'b0;
      sat_row  = 1'b0;

      if (ctl_f.ovf_v) begin
         sat_col = 1'b1;
         col_nx  = ctl_f.neg_v ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (qv > S32_MAX) begin
         sat_col = 1'b1;
         col_nx  = 32'sh7fff_ffff;
      end else if (qv < S32_MIN) begin
         sat_col = 1'b1;
         col_nx  = 32'sh8000_0000;
      end else begin
         col_nx  = qv[31:0];
      end

      if (ctl_f.ovf_u) begin
         sat_row = 1'b1;
         row_nx  = ctl_f.neg_u ? 32'sh7fff_ffff : 32'sh8000_0000;
      end else if (row_full > S32_MAX) begin
         sat_row = 1'b1;
         row_nx  = 32'sh7fff_ffff;
      end else if (row_full < S32_MIN) begin
         sat_row = 1'b1;
         row_nx  = 32'sh8000_0000;
      end else begin
         row_nx  = row_full[31:0];
      end

      status_nx = (sat_col || sat_row) ? ppp_pkg::STATUS_SATURATED : ppp_pkg::STATUS_OK;
      if (ctl_f.zero) begin
         col_nx    = '0;
         row_nx    = '0;
         status_nx = ppp_pkg::STATUS_ZERO_DIV;
      end
   end

   // Output register.
   logic signed [31:0] col_ff, row_ff;
   logic [1:0]         status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= ctl_f.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         col_ff    <= col_nx;
         row_ff    <= row_nx;
         status_ff <= status_nx;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.image_col = col_ff;
   assign rsp.image_row = row_ff;
   assign rsp.status    = status_ff;

endmodule
